// ----- design/bids_pkg.sv -----
// Package for the bitmap integer domain store.
// Holds request/result structs, opcode and mode codes, FSM state type and constants.
// No dependencies.
package bids_pkg;

  localparam int unsigned DOMAIN_BITS_DEF = 256;
  localparam int unsigned WORD_BITS       = 32;
  localparam int unsigned WORD_SHIFT      = $clog2(WORD_BITS);
  localparam int unsigned DATA_W          = 32;
  localparam int unsigned LIMIT_W         = 31;
  localparam int unsigned COUNT_OUT_W     = 9;
  localparam logic [LIMIT_W-1:0] LIMIT_RESET = 31'd255;

  typedef enum logic [2:0] {
    OP_INIT,
    OP_REMOVE,
    OP_RESTRICT,
    OP_ADD_VALUE,
    OP_ADD_RANGE,
    OP_QUERY
  } op_t;

  typedef enum logic [2:0] {
    MODE_KEEP,
    MODE_ZERO,
    MODE_ONES,
    MODE_LOAD,
    MODE_AND,
    MODE_ANDN,
    MODE_OR
  } mode_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_DECODE,
    ST_OFFSET,
    ST_LOW,
    ST_HIGH,
    ST_SCAN,
    ST_LEAST,
    ST_GREAT,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic [2:0]               opcode;
    logic signed [DATA_W-1:0] value_a;
    logic signed [DATA_W-1:0] value_b;
  } req_t;

  typedef struct packed {
    logic signed [DATA_W-1:0]  least_member;
    logic signed [DATA_W-1:0]  greatest_member;
    logic [COUNT_OUT_W-1:0]    member_count;
    logic                      is_empty;
    logic                      is_single;
    logic                      is_member;
  } rsp_t;

  // per-word statistics from the word unit
  typedef struct packed {
    logic [WORD_SHIFT:0]   pop;
    logic                  any;
    logic [WORD_SHIFT-1:0] first;
    logic [WORD_SHIFT-1:0] last;
  } word_stat_t;

endpackage

// ----- design/bids_alu.sv -----
// Shared 32-bit add/subtract unit with registered result.
// Used by the sequencer for offsets, interval ends and member values.
// Depends on bids_pkg.
module bids_alu (
  input  logic                         clk,
  input  logic                         en,
  input  logic                         sub,
  input  logic [bids_pkg::DATA_W-1:0]  x,
  input  logic [bids_pkg::DATA_W-1:0]  y,
  output logic [bids_pkg::DATA_W-1:0]  q
);

  always_ff @(posedge clk) begin
    if (en) begin
      q <= sub ? (x - y) : (x + y);
    end
  end

endmodule

// ----- design/bids_store.sv -----
// Bitmap word memory: one write port, one registered read port.
// Per-word valid bits; a word never written reads as all ones.
// Depends on bids_pkg.
module bids_store #(
  parameter int unsigned WORDS = 8,
  parameter int unsigned AW    = 3
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            rd_en,
  input  logic [AW-1:0]                   rd_addr,
  output logic [bids_pkg::WORD_BITS-1:0]  rd_data,
  input  logic                            wr_en,
  input  logic [AW-1:0]                   wr_addr,
  input  logic [bids_pkg::WORD_BITS-1:0]  wr_data
);

  logic [bids_pkg::WORD_BITS-1:0] mem [WORDS];
  logic [WORDS-1:0]               valid;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= valid[rd_addr] ? mem[rd_addr] : '1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= '0;
    end else if (wr_en) begin
      valid[wr_addr] <= 1'b1;
    end
  end

endmodule

// ----- design/bids_word_op.sv -----
// Word update unit: builds the interval mask for one bitmap word, applies the
// operation mode, and reports popcount and first/last set bit.
// Depends on bids_pkg.
module bids_word_op #(
  parameter int unsigned WORDS     = 8,
  parameter int unsigned AW        = 3,
  parameter int unsigned LAST_FILL = 0
) (
  input  bids_pkg::mode_t                mode,
  input  logic [AW-1:0]                  widx,
  input  logic [bids_pkg::DATA_W-1:0]    span_lo,
  input  logic [bids_pkg::DATA_W-1:0]    span_hi,
  input  logic [bids_pkg::WORD_BITS-1:0] old_word,
  output logic [bids_pkg::WORD_BITS-1:0] new_word,
  output bids_pkg::word_stat_t           stat
);

  localparam int unsigned WB  = bids_pkg::WORD_BITS;
  localparam int unsigned SH  = bids_pkg::WORD_SHIFT;
  localparam int unsigned HW  = bids_pkg::DATA_W - SH;
  localparam logic [WB-1:0] LAST_MASK =
    (LAST_FILL == 0) ? {WB{1'b1}} : ({WB{1'b1}} >> (WB - LAST_FILL));

  logic [HW-1:0] wz;
  logic [WB-1:0] tail, ge_m, le_m, span_m, old_m, upd;
  logic          wrap;

  assign wz   = HW'(widx);
  assign tail = (widx == AW'(WORDS - 1)) ? LAST_MASK : {WB{1'b1}};
  assign wrap = span_hi < span_lo;

  always_comb begin
    if (span_lo[bids_pkg::DATA_W-1:SH] < wz) begin
      ge_m = {WB{1'b1}};
    end else if (span_lo[bids_pkg::DATA_W-1:SH] > wz) begin
      ge_m = '0;
    end else begin
      ge_m = {WB{1'b1}} << span_lo[SH-1:0];
    end
    if (span_hi[bids_pkg::DATA_W-1:SH] > wz) begin
      le_m = {WB{1'b1}};
    end else if (span_hi[bids_pkg::DATA_W-1:SH] < wz) begin
      le_m = '0;
    end else begin
      le_m = ~(({WB{1'b1}} << span_hi[SH-1:0]) << 1);
    end
    span_m = wrap ? (ge_m | le_m) : (ge_m & le_m);
  end

  assign old_m = old_word & tail;

  always_comb begin
    unique case (mode)
      bids_pkg::MODE_KEEP: upd = old_m;
      bids_pkg::MODE_ZERO: upd = '0;
      bids_pkg::MODE_ONES: upd = {WB{1'b1}};
      bids_pkg::MODE_LOAD: upd = span_m;
      bids_pkg::MODE_AND:  upd = old_m & span_m;
      bids_pkg::MODE_ANDN: upd = old_m & ~span_m;
      bids_pkg::MODE_OR:   upd = old_m | span_m;
      default:             upd = old_m;
    endcase
    new_word = upd & tail;
  end

  always_comb begin
    stat.pop   = (SH + 1)'($countones(new_word));
    stat.any   = |new_word;
    stat.first = '0;
    stat.last  = '0;
    for (int i = WB - 1; i >= 0; i--) begin
      if (new_word[i]) stat.first = SH'(i);
    end
    for (int i = 0; i < WB; i++) begin
      if (new_word[i]) stat.last = SH'(i);
    end
  end

endmodule

// ----- design/bitmap_integer_domain_store_unit.sv -----
// Top level of the bitmap integer domain store: sequencer, state registers,
// shared ALU, word memory and word update unit.
// Depends on bids_pkg, bids_alu, bids_store, bids_word_op.
//
//  channel   | signals                 | handshake
//  ----------+-------------------------+----------------------------------
//  request   | start, busy, request    | taken when start && !busy
//  result    | done, result            | one-cycle strobe, no backpressure
//  config    | cfg_we, cfg_wdata       | written when cfg_we, no wait
//
// From acceptance, a request steps through DECODE, OFFSET, LOW, HIGH, a word
// scan through the single read port, then LEAST, GREAT and DONE (result strobe);
// the scan sets most of the time, the rest is the shared adder's setup and output
// steps. busy is low again the cycle after done. Synchronous reset restores the
// full default domain at once (per-word valid bits), no clearing pass.
module bitmap_integer_domain_store_unit #(
  parameter int unsigned DOMAIN_BITS = bids_pkg::DOMAIN_BITS_DEF
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           start,
  output logic                           busy,
  input  bids_pkg::req_t                 request,
  output logic                           done,
  output bids_pkg::rsp_t                 result,
  input  logic                           cfg_we,
  input  logic [bids_pkg::LIMIT_W-1:0]   cfg_wdata
);

  localparam int unsigned DW    = bids_pkg::DATA_W;
  localparam int unsigned WB    = bids_pkg::WORD_BITS;
  localparam int unsigned SH    = bids_pkg::WORD_SHIFT;
  localparam int unsigned WORDS = (DOMAIN_BITS + WB - 1) / WB;
  localparam int unsigned AW    = (WORDS > 1) ? $clog2(WORDS) : 1;
  localparam int unsigned PW    = AW + SH;
  localparam int unsigned CW    = $clog2(DOMAIN_BITS + 1);
  localparam logic [DW-1:0] TOP_POS = DW'(DOMAIN_BITS - 1);

  bids_pkg::state_t state, state_next;

  logic [bids_pkg::LIMIT_W-1:0] direct_limit;
  logic [2:0]                   op;
  logic [DW-1:0]                val_a, val_b, lo, hi;
  logic [DW-1:0]                base_offset, first_low, first_high;
  logic [DW-1:0]                pos_a, span_lo, least_q;
  logic                         set_def, set_gen, need_neg;
  bids_pkg::mode_t              mode;
  logic [AW-1:0]                widx;
  logic [CW-1:0]                live_count;
  logic [PW-1:0]                low_index, high_index;
  logic                         seen, member;

  logic                         alu_en, alu_sub;
  logic [DW-1:0]                alu_x, alu_y, alu_q, off_eff;
  logic                         rd_en;
  logic [AW-1:0]                rd_addr;
  logic [WB-1:0]                rd_data, new_word;
  bids_pkg::word_stat_t         stat;
  logic                         last_word;
  logic                         empty;

  assign busy      = (state != bids_pkg::ST_IDLE);
  assign done      = (state == bids_pkg::ST_DONE);
  assign last_word = (widx == AW'(WORDS - 1));
  assign empty     = (live_count == '0);
  assign off_eff   = (op == bids_pkg::OP_INIT) ?
                     ((set_gen && need_neg) ? alu_q : '0) : base_offset;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= bids_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    alu_en     = 1'b0;
    alu_sub    = 1'b0;
    alu_x      = '0;
    alu_y      = '0;
    rd_en      = 1'b0;
    rd_addr    = '0;
    unique case (state)
      bids_pkg::ST_IDLE: begin
        if (start) state_next = bids_pkg::ST_DECODE;
      end
      bids_pkg::ST_DECODE: begin
        alu_en     = 1'b1;
        alu_sub    = 1'b1;
        alu_y      = val_a;
        state_next = bids_pkg::ST_OFFSET;
      end
      bids_pkg::ST_OFFSET: begin
        alu_en     = 1'b1;
        alu_x      = val_a;
        alu_y      = off_eff;
        state_next = bids_pkg::ST_LOW;
      end
      bids_pkg::ST_LOW: begin
        alu_en     = 1'b1;
        alu_x      = lo;
        alu_y      = base_offset;
        state_next = bids_pkg::ST_HIGH;
      end
      bids_pkg::ST_HIGH: begin
        alu_en     = 1'b1;
        alu_x      = hi;
        alu_y      = base_offset;
        rd_en      = 1'b1;
        state_next = bids_pkg::ST_SCAN;
      end
      bids_pkg::ST_SCAN: begin
        rd_en   = !last_word;
        rd_addr = widx + AW'(1);
        if (last_word) state_next = bids_pkg::ST_LEAST;
      end
      bids_pkg::ST_LEAST: begin
        alu_en     = 1'b1;
        alu_sub    = 1'b1;
        alu_x      = DW'(low_index);
        alu_y      = base_offset;
        state_next = bids_pkg::ST_GREAT;
      end
      bids_pkg::ST_GREAT: begin
        alu_en     = 1'b1;
        alu_sub    = 1'b1;
        alu_x      = DW'(high_index);
        alu_y      = base_offset;
        state_next = bids_pkg::ST_DONE;
      end
      bids_pkg::ST_DONE: begin
        state_next = bids_pkg::ST_IDLE;
      end
      default: state_next = bids_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      direct_limit <= bids_pkg::LIMIT_RESET;
    end else if (cfg_we) begin
      direct_limit <= cfg_wdata;
    end
  end

  // domain registers
  always_ff @(posedge clk) begin
    if (rst) begin
      base_offset <= '0;
      first_low   <= '0;
      first_high  <= TOP_POS;
      live_count  <= CW'(DOMAIN_BITS);
      low_index   <= '0;
      high_index  <= PW'(DOMAIN_BITS - 1);
    end else begin
      if (state == bids_pkg::ST_OFFSET && op == bids_pkg::OP_INIT) begin
        base_offset <= off_eff;
        first_low   <= set_gen ? val_a : '0;
        first_high  <= set_gen ? val_b : TOP_POS;
      end
      if (state == bids_pkg::ST_HIGH) begin
        live_count <= '0;
        low_index  <= '0;
        high_index <= '0;
      end
      if (state == bids_pkg::ST_SCAN) begin
        live_count <= live_count + CW'(stat.pop);
        if (stat.any) begin
          high_index <= {widx, stat.last};
          if (!seen) low_index <= {widx, stat.first};
        end
      end
    end
  end

  // per-request work registers
  always_ff @(posedge clk) begin
    if (state == bids_pkg::ST_IDLE && start) begin
      op    <= request.opcode;
      val_a <= request.value_a;
      val_b <= request.value_b;
    end
    if (state == bids_pkg::ST_DECODE) begin
      set_def  <= 1'b0;
      set_gen  <= 1'b0;
      need_neg <= 1'b0;
      lo       <= val_a;
      hi       <= val_a;
      mode     <= bids_pkg::MODE_KEEP;
      case (op)
        bids_pkg::OP_INIT: begin
          hi <= val_b;
          if ($signed(val_b) < $signed(val_a)) begin
            mode    <= bids_pkg::MODE_ZERO;
            set_def <= 1'b1;
          end else if ($signed(val_a) <= 0 && $signed(val_b) >= $signed(TOP_POS)) begin
            mode    <= bids_pkg::MODE_ONES;
            set_def <= 1'b1;
          end else begin
            mode     <= bids_pkg::MODE_LOAD;
            set_gen  <= 1'b1;
            need_neg <= val_a[DW-1] || (val_a[DW-2:0] > direct_limit);
          end
        end
        bids_pkg::OP_REMOVE: mode <= bids_pkg::MODE_ANDN;
        bids_pkg::OP_RESTRICT: begin
          hi   <= val_b;
          mode <= ($signed(val_b) < $signed(val_a)) ? bids_pkg::MODE_ZERO
                                                    : bids_pkg::MODE_AND;
        end
        bids_pkg::OP_ADD_VALUE: begin
          mode <= bids_pkg::MODE_OR;
          if ($signed(first_high) < $signed(val_a) &&
              !($signed(val_a) < $signed(first_low))) begin
            lo <= first_high;
            hi <= first_high;
          end else if ($signed(val_a) < $signed(first_low)) begin
            lo <= ($signed(first_low) > $signed(first_high)) ? first_high : first_low;
            hi <= ($signed(first_low) > $signed(first_high)) ? first_high : first_low;
          end
        end
        bids_pkg::OP_ADD_RANGE: begin
          mode <= bids_pkg::MODE_OR;
          lo   <= ($signed(val_a) > $signed(first_low)) ? val_a : first_low;
          hi   <= ($signed(val_b) < $signed(first_high)) ? val_b : first_high;
        end
        default: mode <= bids_pkg::MODE_KEEP;
      endcase
    end
    if (state == bids_pkg::ST_OFFSET && op == bids_pkg::OP_ADD_RANGE &&
        $signed(hi) < $signed(lo)) begin
      mode <= bids_pkg::MODE_KEEP;
    end
    if (state == bids_pkg::ST_LOW) pos_a <= alu_q;
    if (state == bids_pkg::ST_HIGH) begin
      span_lo <= alu_q;
      widx    <= '0;
      seen    <= 1'b0;
      member  <= 1'b0;
    end
    if (state == bids_pkg::ST_SCAN) begin
      widx <= widx + AW'(1);
      if (stat.any) seen <= 1'b1;
      if (pos_a[DW-1:SH] == (DW - SH)'(widx)) member <= new_word[pos_a[SH-1:0]];
    end
    if (state == bids_pkg::ST_GREAT) least_q <= alu_q;
  end

  bids_alu u_alu (
    .clk (clk),
    .en  (alu_en),
    .sub (alu_sub),
    .x   (alu_x),
    .y   (alu_y),
    .q   (alu_q)
  );

  bids_store #(
    .WORDS (WORDS),
    .AW    (AW)
  ) u_store (
    .clk     (clk),
    .rst     (rst),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data),
    .wr_en   (state == bids_pkg::ST_SCAN),
    .wr_addr (widx),
    .wr_data (new_word)
  );

  // span_hi comes straight from the held ALU result during the scan
  bids_word_op #(
    .WORDS     (WORDS),
    .AW        (AW),
    .LAST_FILL (DOMAIN_BITS % WB)
  ) u_word (
    .mode     (mode),
    .widx     (widx),
    .span_lo  (span_lo),
    .span_hi  (alu_q),
    .old_word (rd_data),
    .new_word (new_word),
    .stat     (stat)
  );

  always_comb begin
    result.least_member    = empty ? '0 : least_q;
    result.greatest_member = empty ? '0 : alu_q;
    result.member_count    = bids_pkg::COUNT_OUT_W'(live_count);
    result.is_empty        = empty;
    result.is_single       = (live_count == CW'(1));
    result.is_member       = member;
  end

endmodule

// ----- design/bids_chk.sv -----
// Port-level checker for the bitmap integer domain store, with its bind.
// Depends on bids_pkg and bitmap_integer_domain_store_unit.
module bids_chk (
  input logic           clk,
  input logic           rst,
  input logic           start,
  input logic           busy,
  input logic           done,
  input bids_pkg::rsp_t result
);

  a_done_busy: assert property (@(posedge clk) disable iff (rst)
    done |-> busy) else $error("result strobe while idle");

  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> (busy && !done)) else $error("request not taken");

  a_done_pulse: assert property (@(posedge clk) disable iff (rst)
    done |=> (!done && !busy)) else $error("result strobe not a single cycle");

  a_fell_after_done: assert property (@(posedge clk) disable iff (rst)
    $fell(busy) |-> $past(done)) else $error("busy dropped without a result");

  a_empty_zero: assert property (@(posedge clk) disable iff (rst)
    (done && result.is_empty) |-> (result.least_member == '0 &&
      result.greatest_member == '0 && !result.is_member && !result.is_single))
    else $error("empty result with members");

endmodule

bind bitmap_integer_domain_store_unit bids_chk u_bids_chk (
  .clk    (clk),
  .rst    (rst),
  .start  (start),
  .busy   (busy),
  .done   (done),
  .result (result)
);
